// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition in %m");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/nerl_pkg.sv =====
// ----------------------------------------------------------------------------
// nerl_pkg
// Types and constants of the numbered event ring log.
// ----------------------------------------------------------------------------
package nerl_pkg;

  localparam int unsigned NumW   = 64;
  localparam int unsigned LimitW = 5;
  localparam logic [LimitW-1:0] MaxOut = LimitW'(16);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [15:0]       key_code;
    logic [7:0]        action_code;
    logic [15:0]       modifier_mask;
    logic [NumW-1:0]   timestamp_ms;
    logic [NumW-1:0]   consumed_number;
    logic [LimitW-1:0] record_limit;
  } in_item_t;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic [NumW-1:0] stamp;
    logic [15:0]     key;
    logic [7:0]      action;
    logic [15:0]     modifiers;
  } rec_t;

  typedef struct packed {
    logic            record_valid;
    logic [NumW-1:0] rec_number;
    logic [NumW-1:0] event_time;
    logic [15:0]     event_key;
    logic [7:0]      event_action;
    logic [15:0]     event_modifiers;
    logic            missed;
    logic [NumW-1:0] oldest_held;
    logic [NumW-1:0] newest_held;
    logic            last_of_run;
  } out_item_t;

endpackage

// ===== hdl/nerl_ring_mem.sv =====
// ----------------------------------------------------------------------------
// nerl_ring_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nerl_ring_mem import nerl_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(LOG_DEPTH)-1:0] waddr_i,
  input  rec_t                         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(LOG_DEPTH)-1:0] raddr_i,
  output rec_t                         rdata_o
);

  rec_t mem [LOG_DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nerl_out_reg.sv =====
// ----------------------------------------------------------------------------
// nerl_out_reg
// Output holding register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module nerl_out_reg import nerl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t data_i,
  output logic      ok_o,
  input  logic      ready_i,
  output logic      valid_o,
  output out_item_t data_o
);

  logic      vld_q, vld_d;
  out_item_t data_q;

  assign ok_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/nerl_ctrl.sv =====
// ----------------------------------------------------------------------------
// nerl_ctrl
// Ring pointers, number counters and the read-since scan sequencer.
// ----------------------------------------------------------------------------
module nerl_ctrl import nerl_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  in_item_t                     in_i,
  input  logic                         out_ok_i,
  output logic                         out_load_o,
  output out_item_t                    out_o,
  output logic                         we_o,
  output logic [$clog2(LOG_DEPTH)-1:0] waddr_o,
  output rec_t                         wdata_o,
  output logic                         re_o,
  output logic [$clog2(LOG_DEPTH)-1:0] raddr_o,
  input  rec_t                         rdata_i
);

  localparam int unsigned SW = $clog2(LOG_DEPTH);
  localparam int unsigned FW = $clog2(LOG_DEPTH + 1);
  localparam logic [SW-1:0] LastSlot = SW'(LOG_DEPTH - 1);
  localparam logic [FW-1:0] DepthF   = FW'(LOG_DEPTH);
  localparam logic [SW:0]   DepthS   = (SW+1)'(LOG_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s == LastSlot) ? '0 : s + SW'(1);
    return r;
  endfunction

  function automatic out_item_t mk_out(input logic vld, input rec_t rec, input logic mis,
                                       input logic [NumW-1:0] old_n,
                                       input logic [NumW-1:0] new_n, input logic last);
    out_item_t o;
    o.record_valid    = vld;
    o.rec_number      = vld ? rec.number : '0;
    o.event_time      = vld ? rec.stamp : '0;
    o.event_key       = vld ? rec.key : '0;
    o.event_action    = vld ? rec.action : '0;
    o.event_modifiers = vld ? rec.modifiers : '0;
    o.missed          = mis;
    o.oldest_held     = old_n;
    o.newest_held     = new_n;
    o.last_of_run     = last;
    return o;
  endfunction

  state_e            state_q, state_d;
  logic [SW-1:0]     oldest_slot_q, oldest_slot_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [NumW-1:0]   next_num_q, next_num_d;
  logic [NumW-1:0]   oldest_num_q, oldest_num_d;
  logic [NumW-1:0]   newest_num_q, newest_num_d;
  logic [NumW-1:0]   want_q, want_d;
  logic              at_top_q, at_top_d;
  logic              missed_q, missed_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [LimitW-1:0] hits_q, hits_d;
  logic [FW-1:0]     off_q, off_d;
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic              rd_vld_q, rd_vld_d;
  logic              pend_vld_q, pend_vld_d;
  rec_t              pend_q, pend_d;

  logic              accept;
  logic              full;
  logic [SW:0]       slot_sum;
  logic [SW-1:0]     wslot;
  logic              at_top;
  logic [NumW-1:0]   cons_inc;
  logic              missed;
  logic              hit;
  logic              push_mid;
  logic              stall;
  logic              more;
  rec_t              new_rec;

  assign full     = (fill_q == DepthF);
  assign slot_sum = {1'b0, oldest_slot_q} + (SW+1)'(fill_q);
  assign wslot    = full ? oldest_slot_q
                  : (slot_sum >= DepthS) ? SW'(slot_sum - DepthS) : slot_sum[SW-1:0];

  assign at_top   = &in_i.consumed_number;
  assign cons_inc = in_i.consumed_number + NumW'(1);
  assign missed   = (fill_q != '0) && (in_i.consumed_number != '0) && !at_top &&
                    (cons_inc < oldest_num_q);

  assign hit      = rd_vld_q && !at_top_q && (rdata_i.number >= want_q);
  assign push_mid = hit && pend_vld_q;
  assign stall    = push_mid && !out_ok_i;
  assign more     = (off_q != fill_q);

  assign in_ready_o = (state_q == ST_IDLE) && out_ok_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    new_rec.number    = next_num_q;
    new_rec.stamp     = in_i.timestamp_ms;
    new_rec.key       = in_i.key_code;
    new_rec.action    = in_i.action_code;
    new_rec.modifiers = in_i.modifier_mask;
  end

  assign wdata_o = new_rec;
  assign waddr_o = wslot;
  assign raddr_o = rd_slot_q;

  always_comb begin
    state_d       = state_q;
    oldest_slot_d = oldest_slot_q;
    fill_d        = fill_q;
    next_num_d    = next_num_q;
    oldest_num_d  = oldest_num_q;
    newest_num_d  = newest_num_q;
    want_d        = want_q;
    at_top_d      = at_top_q;
    missed_d      = missed_q;
    limit_d       = limit_q;
    hits_d        = hits_q;
    off_d         = off_q;
    rd_slot_d     = rd_slot_q;
    rd_vld_d      = rd_vld_q;
    pend_vld_d    = pend_vld_q;
    pend_d        = pend_q;
    we_o          = 1'b0;
    re_o          = 1'b0;
    out_load_o    = 1'b0;
    out_o         = mk_out(1'b0, pend_q, missed_q, oldest_num_q, newest_num_q, 1'b1);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_APPEND) begin
            we_o = 1'b1;
            if (full) begin
              oldest_slot_d = inc_slot(oldest_slot_q);
              oldest_num_d  = oldest_num_q + NumW'(1);
            end else begin
              fill_d = fill_q + FW'(1);
              if (fill_q == '0) begin
                oldest_num_d = next_num_q;
              end
            end
            newest_num_d = next_num_q;
            next_num_d   = next_num_q + NumW'(1);
            out_load_o   = 1'b1;
            out_o        = mk_out(1'b1, new_rec, 1'b0, oldest_num_d, next_num_q, 1'b1);
          end else begin
            at_top_d   = at_top;
            missed_d   = missed;
            want_d     = missed ? oldest_num_q : cons_inc;
            limit_d    = (in_i.record_limit > MaxOut) ? MaxOut : in_i.record_limit;
            hits_d     = '0;
            off_d      = '0;
            rd_slot_d  = oldest_slot_q;
            rd_vld_d   = 1'b0;
            pend_vld_d = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        out_o = mk_out(1'b1, pend_q, missed_q, oldest_num_q, newest_num_q, 1'b0);
        if (!stall) begin
          out_load_o = push_mid;
          if (hit) begin
            pend_d     = rdata_i;
            pend_vld_d = 1'b1;
            hits_d     = hits_q + LimitW'(1);
          end
          re_o     = more;
          rd_vld_d = more;
          if (more) begin
            off_d     = off_q + FW'(1);
            rd_slot_d = inc_slot(rd_slot_q);
          end
          if (!more || (hits_d == limit_q)) begin
            rd_vld_d = 1'b0;
            state_d  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        out_o = mk_out(pend_vld_q, pend_q, missed_q, oldest_num_q, newest_num_q, 1'b1);
        if (out_ok_i) begin
          out_load_o = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      oldest_slot_q <= '0;
      fill_q        <= '0;
      next_num_q    <= NumW'(1);
      oldest_num_q  <= '0;
      newest_num_q  <= '0;
      at_top_q      <= 1'b0;
      missed_q      <= 1'b0;
      limit_q       <= '0;
      hits_q        <= '0;
      off_q         <= '0;
      rd_slot_q     <= '0;
      rd_vld_q      <= 1'b0;
      pend_vld_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      oldest_slot_q <= oldest_slot_d;
      fill_q        <= fill_d;
      next_num_q    <= next_num_d;
      oldest_num_q  <= oldest_num_d;
      newest_num_q  <= newest_num_d;
      at_top_q      <= at_top_d;
      missed_q      <= missed_d;
      limit_q       <= limit_d;
      hits_q        <= hits_d;
      off_q         <= off_d;
      rd_slot_q     <= rd_slot_d;
      rd_vld_q      <= rd_vld_d;
      pend_vld_q    <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q <= want_d;
    pend_q <= pend_d;
  end

endmodule

// ===== hdl/numbered_event_ring_log.sv =====
// ----------------------------------------------------------------------------
// numbered_event_ring_log
// Numbered event log in a ring that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser selects append (0) or read-since (1); tdata
// carries the event fields and, for a read, the consumed number and limit.
// Result stream m_axis: tuser flags a carried record, tlast marks the final
// result of an item; tdata carries the record and the held number range.
// An append writes one ring entry and returns its record in the cycle after
// acceptance as a single last-marked result; the next item can be taken in
// the following cycle if the receiver is ready.
// A read-since scans the held entries oldest first, one ring read per
// cycle while the result channel is not stalled, and ends early once the
// limit is reached. A read with no match returns one empty last-marked
// result.
// A result waits in an output register while the receiver stalls; the scan
// holds in place until that register frees up.
// Reset empties the log and restarts numbering at 1; ring contents are left
// as they are and are never read before written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numbered_event_ring_log import nerl_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_code[15:0], action_code[23:16], modifier_mask[39:24],
  // timestamp_ms[103:40], consumed_number[167:104], record_limit[172:168]
  input  logic [175:0] s_axis_tdata,
  // opcode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rec_number[63:0], event_time[127:64], event_key[143:128],
  // event_action[151:144], event_modifiers[167:152], missed[168],
  // oldest_held[232:169], newest_held[296:233]
  output logic [303:0] m_axis_tdata,
  // record_valid[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned SW = $clog2(LOG_DEPTH);

  in_item_t      in_item;
  out_item_t     ctrl_out;
  out_item_t     out_q;
  logic          out_ok;
  logic          out_load;
  logic          out_empty;
  logic          we;
  logic          re;
  logic [SW-1:0] waddr;
  logic [SW-1:0] raddr;
  rec_t          wdata;
  rec_t          rdata;

  always_comb begin
    in_item.opcode          = opcode_e'(s_axis_tuser);
    in_item.key_code        = s_axis_tdata[15:0];
    in_item.action_code     = s_axis_tdata[23:16];
    in_item.modifier_mask   = s_axis_tdata[39:24];
    in_item.timestamp_ms    = s_axis_tdata[103:40];
    in_item.consumed_number = s_axis_tdata[167:104];
    in_item.record_limit    = s_axis_tdata[172:168];
  end

  nerl_ctrl #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_i       (in_item),
    .out_ok_i   (out_ok),
    .out_load_o (out_load),
    .out_o      (ctrl_out),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  nerl_ring_mem #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nerl_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (ctrl_out),
    .ok_o    (out_ok),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_q)
  );

  assign m_axis_tdata = {7'b0, out_q.newest_held, out_q.oldest_held, out_q.missed,
                         out_q.event_modifiers, out_q.event_action, out_q.event_key,
                         out_q.event_time, out_q.rec_number};
  assign m_axis_tuser = out_q.record_valid;
  assign m_axis_tlast = out_q.last_of_run;

  assign out_empty = m_axis_tvalid && !out_q.record_valid;

  `ASSERT_PROP(a_empty_is_last, clk_i, rst_ni, out_empty |-> out_q.last_of_run)
  `ASSERT_PROP(a_empty_zero, clk_i, rst_ni, out_empty |-> (out_q.rec_number == '0))
  `ASSERT_NEVER(a_no_take_on_stall, clk_i, rst_ni, s_axis_tready && m_axis_tvalid && !m_axis_tready)
  `ASSERT_NEVER(a_no_load_on_stall, clk_i, rst_ni, out_load && m_axis_tvalid && !m_axis_tready)

endmodule
